// ===== src/upc_pkg.sv =====
// shared types, codes and character helpers for the uri percent codec
package upc_pkg;

  localparam logic [1:0] MODE_ENCODE    = 2'd0;
  localparam logic [1:0] MODE_DECODE    = 2'd1;
  localparam logic [1:0] MODE_DECODE_UR = 2'd2;
  localparam logic [1:0] MODE_NORMALISE = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HEX1 = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] HEX_SKEW   = 8'd39;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       trunc;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } res_set_t;

  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e ||
           c == 8'h5f || c == 8'h7e;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = to_lower(c) - 8'h30;
    if (d > 8'd9 && d < 8'd128) d = d - HEX_SKEW;
    return d;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
  endfunction

endpackage

// ===== src/uri_percent_codec.sv =====
// top level of the uri percent codec: input register, core and result buffer
//
// Byte-stream percent codec for URI text. The input channel (in_valid,
// in_stall, in_byte, in_last) carries one character per transaction, with
// in_last on the final character of a string. The output channel (out_valid,
// out_stall, out_byte, has_byte, out_last, truncated) carries one result
// character per transaction; a bare end marker (has_byte 0, truncated 1)
// closes a string that ended inside an escape.
// The mode register is written over cfg_valid/cfg_ready/cfg_mode: 0 encode,
// 1 decode, 2 decode unreserved only, 3 normalise. The user must write it
// only while the block is idle; the block itself does not enforce this.
// A character passes the input register and then the result buffer, which
// sends one result per cycle while the receiver does not stall. A character
// gives one result, none or a triple, and the next loads as its last leaves.
// Reset clears the mode to encode, drops any pending escape and empties
// both the input register and the result buffer. While the receiver
// stalls, the current result holds and in_stall rises once the input
// register is occupied and the result buffer cannot take its results.
module uri_percent_codec import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last,
  output logic       truncated
);

  logic [1:0] mode;
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_last;
  logic       a_move;
  logic       can_load;
  res_set_t   res_set;

  assign cfg_ready = 1'b1;
  assign a_move    = a_valid && can_load;
  assign in_stall  = a_valid && !a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_byte <= in_byte;
      a_last <= in_last;
    end
  end

  upc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .step      (a_move),
    .item_byte (a_byte),
    .item_last (a_last),
    .res_set   (res_set)
  );

  upc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (a_move),
    .res_set   (res_set),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last),
    .truncated (truncated)
  );

  // stall only while a character waits in the input register
  assert property (@(posedge clk) disable iff (rst) in_stall |-> a_valid)
    else $error("in_stall without a held character");

  // a truncation marker carries no character and closes the string
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> (!has_byte && out_last && out_byte == 8'd0))
    else $error("malformed truncation marker");

  // a character held in the input register moves on once the buffer drains
  assert property (@(posedge clk) disable iff (rst)
    (a_valid && !out_valid) |-> a_move)
    else $error("input register stuck with an empty result buffer");

endmodule

// ===== src/upc_core.sv =====
// escape tracking state and per-character result computation
module upc_core import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] mode,
  input  logic       step,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  output res_set_t   res_set
);

  logic [1:0] phase, phase_next;
  logic [7:0] first_hex, first_hex_next;
  logic [7:0] hi, lo, dec;

  always_comb begin
    hi  = nibble_of(first_hex);
    lo  = nibble_of(item_byte);
    dec = {hi[3:0], 4'd0} | lo;
  end

  always_comb begin
    phase_next     = phase;
    first_hex_next = first_hex;
    res_set        = '0;
    if (mode == MODE_ENCODE) begin
      phase_next = PH_IDLE;
      if (is_unreserved(item_byte)) begin
        res_set.count = 2'd1;
        res_set.r0    = '{item_byte, 1'b1, item_last, 1'b0};
      end else begin
        res_set.count = 2'd3;
        res_set.r0    = '{CH_PERCENT, 1'b1, 1'b0, 1'b0};
        res_set.r1    = '{hex_char(item_byte[7:4]), 1'b1, 1'b0, 1'b0};
        res_set.r2    = '{hex_char(item_byte[3:0]), 1'b1, item_last, 1'b0};
      end
    end else if (phase == PH_PCT) begin
      first_hex_next = item_byte;
      phase_next     = PH_HEX1;
      if (item_last) begin
        phase_next    = PH_IDLE;
        res_set.count = 2'd1;
        res_set.r0    = '{8'd0, 1'b0, 1'b1, 1'b1};
      end
    end else if (phase == PH_HEX1) begin
      phase_next = PH_IDLE;
      if (mode == MODE_DECODE || (mode == MODE_DECODE_UR && is_unreserved(dec))) begin
        res_set.count = 2'd1;
        res_set.r0    = '{dec, 1'b1, item_last, 1'b0};
      end else begin
        res_set.count = 2'd3;
        res_set.r0    = '{CH_PERCENT, 1'b1, 1'b0, 1'b0};
        res_set.r1    = '{to_upper(first_hex), 1'b1, 1'b0, 1'b0};
        res_set.r2    = '{to_upper(item_byte), 1'b1, item_last, 1'b0};
      end
    end else if (item_byte == CH_PERCENT) begin
      phase_next = PH_PCT;
      if (item_last) begin
        phase_next    = PH_IDLE;
        res_set.count = 2'd1;
        res_set.r0    = '{8'd0, 1'b0, 1'b1, 1'b1};
      end
    end else begin
      phase_next    = PH_IDLE;
      res_set.count = 2'd1;
      res_set.r0    = '{item_byte, 1'b1, item_last, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      first_hex <= 8'd0;
    end else if (step) begin
      phase     <= phase_next;
      first_hex <= first_hex_next;
    end
  end

endmodule

// ===== src/upc_out_buf.sv =====
// result register that holds up to three results and sends one per cycle while out_stall is low
module upc_out_buf import upc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  res_set_t   res_set,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       has_byte,
  output logic       out_last,
  output logic       truncated
);

  logic [1:0] rem;
  res_t       e0, e1, e2;
  logic       fire;

  assign fire      = (rem != 2'd0) && !out_stall;
  assign can_load  = (rem == 2'd0) || (rem == 2'd1 && fire);
  assign out_valid = (rem != 2'd0);
  assign out_byte  = e0.data;
  assign has_byte  = e0.has;
  assign out_last  = e0.last;
  assign truncated = e0.trunc;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load && can_load) begin
      rem <= res_set.count;
    end else if (fire) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      e0 <= res_set.r0;
      e1 <= res_set.r1;
      e2 <= res_set.r2;
    end else if (fire) begin
      e0 <= e1;
      e1 <= e2;
    end
  end

endmodule

// ===== test/uri_percent_codec_tb.sv =====
// self-checking testbench for the uri percent codec with a behavioral predictor
module uri_percent_codec_tb;
  import upc_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       has;
    logic       last;
    logic       trunc;
  } text_char_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_mode;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       out_last;
  logic       truncated;

  // predictor state
  logic [1:0] cur_mode = MODE_ENCODE;
  logic [1:0] esc_phase = PH_IDLE;
  logic [7:0] esc_first = 8'h00;
  text_char_t pending_chars[$];

  int  fail_count = 0;
  int  hold_request = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;

  uri_percent_codec dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_mode  (cfg_mode),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .has_byte  (has_byte),
    .out_last  (out_last),
    .truncated (truncated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit url_safe(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
           c == "-" || c == "." || c == "_" || c == "~";
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // escape digit weight, with the signed skew applied to non-hex characters
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = ((c >= "A" && c <= "Z") ? c + 8'd32 : c) - 8'h30;
    if (!d[7] && d > 8'd9) begin
      d = d - 8'd39;
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n > 4'd9) ? 8'("A") + 8'(n) - 8'd10 : 8'("0") + 8'(n);
  endfunction

  function automatic void expect_char(input logic [7:0] v, input logic h, input logic l,
                                      input logic t);
    text_char_t e;
    e.value = v;
    e.has = h;
    e.last = l;
    e.trunc = t;
    pending_chars.push_back(e);
  endfunction

  function automatic void predict_codec_output(input logic [7:0] c, input logic l);
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] value;
    if (cur_mode == MODE_ENCODE) begin
      esc_phase = PH_IDLE;
      if (url_safe(c)) begin
        expect_char(c, 1'b1, l, 1'b0);
      end else begin
        expect_char(CH_PERCENT, 1'b1, 1'b0, 1'b0);
        expect_char(hex_digit(c[7:4]), 1'b1, 1'b0, 1'b0);
        expect_char(hex_digit(c[3:0]), 1'b1, l, 1'b0);
      end
      return;
    end
    case (esc_phase)
      PH_PCT: begin
        esc_first = c;
        esc_phase = PH_HEX1;
      end
      PH_HEX1: begin
        hi = digit_value(esc_first);
        lo = digit_value(c);
        value = {hi[3:0], 4'h0} | lo;
        esc_phase = PH_IDLE;
        if (cur_mode == MODE_DECODE || (cur_mode == MODE_DECODE_UR && url_safe(value))) begin
          expect_char(value, 1'b1, l, 1'b0);
        end else begin
          expect_char(CH_PERCENT, 1'b1, 1'b0, 1'b0);
          expect_char(upcase(esc_first), 1'b1, 1'b0, 1'b0);
          expect_char(upcase(c), 1'b1, l, 1'b0);
        end
        return;
      end
      default: begin
        if (c == CH_PERCENT) begin
          esc_phase = PH_PCT;
        end else begin
          esc_phase = PH_IDLE;
          expect_char(c, 1'b1, l, 1'b0);
          return;
        end
      end
    endcase
    // string ended inside an escape
    if (l) begin
      esc_phase = PH_IDLE;
      expect_char(8'h00, 1'b0, 1'b1, 1'b1);
    end
  endfunction

  // result checker
  always @(negedge clk) begin
    text_char_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected transaction: byte %02h has %0d last %0d trunc %0d",
                   out_byte, has_byte, out_last, truncated);
        end
        fail_count++;
      end else begin
        e = pending_chars.pop_front();
        if (out_byte !== e.value || has_byte !== e.has || out_last !== e.last ||
            truncated !== e.trunc) begin
          if (fail_count < 10) begin
            $display("mismatch: expected %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                     e.value, e.has, e.last, e.trunc, out_byte, has_byte, out_last,
                     truncated);
          end
          fail_count++;
        end
      end
    end
  end

  // receiver
  initial begin : receiver
    int  wait_n;
    logic got;
    forever begin
      if (hold_request > 0) begin
        wait_n = hold_request;
        hold_request = 0;
      end else begin
        wait_n = recv_idle ? $urandom_range(0, 10) : 0;
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        got = out_valid && !rst;
        @(posedge clk);
      end while (!got);
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_char(input logic [7:0] c, input logic l);
    int   gap;
    logic taken;
    gap = send_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= c;
    in_last <= l;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    predict_codec_output(c, l);
  endtask

  task automatic send_string(input string s, input logic end_mark);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], end_mark && i == s.len() - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    logic rdy;
    drain();
    cfg_valid <= 1'b1;
    cfg_mode <= m;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
    cur_mode = m;
  endtask

  function automatic logic [7:0] random_hex_char();
    logic [7:0] c;
    c = hex_digit(4'($urandom_range(0, 15)));
    if (c >= "A" && $urandom_range(0, 1)) begin
      c = c + 8'd32;
    end
    return c;
  endfunction

  task automatic test_encode_extremes();
    set_mode(MODE_ENCODE);
    send_string("Za9-~", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b1);
  endtask

  task automatic test_decode_escapes();
    set_mode(MODE_DECODE);
    send_string("%4a", 1'b0);
    send_string("%G%", 1'b0);
    send_char("x", 1'b1);
    send_string("%7", 1'b1);
    send_string("%", 1'b1);
  endtask

  task automatic test_decode_unreserved();
    set_mode(MODE_DECODE_UR);
    send_string("%41", 1'b0);
    send_string("%2f", 1'b1);
  endtask

  task automatic test_normalise();
    set_mode(MODE_NORMALISE);
    send_string("%ab", 1'b1);
  endtask

  task automatic test_escape_across_mode_change();
    set_mode(MODE_DECODE);
    send_char(CH_PERCENT, 1'b0);
    set_mode(MODE_ENCODE);
    send_char("4", 1'b0);
    set_mode(MODE_DECODE);
    send_string("41", 1'b1);
  endtask

  task automatic test_backpressure();
    send_idle = 1'b0;
    set_mode(MODE_ENCODE);
    hold_request = 80;
    for (int i = 0; i < 30; i++) begin
      send_char(8'($urandom_range(128, 255)), i == 29);
    end
    send_idle = 1'b1;
  endtask

  task automatic test_random_strings();
    logic [7:0] text[$];
    int         len;
    int         pick;
    int         sent;
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
      send_idle = (ph != 1 && ph != 3);
      recv_idle = (ph != 1 && ph != 2);
      sent = 0;
      while (sent < 25) begin
        text.delete();
        len = $urandom_range(1, 10);
        while (text.size() < len) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            text.push_back(CH_PERCENT);
            text.push_back(random_hex_char());
            text.push_back(random_hex_char());
          end else if (pick == 3) begin
            text.push_back(CH_PERCENT);
            text.push_back(8'($urandom_range(0, 255)));
          end else if (pick < 6) begin
            text.push_back(8'("a") + 8'($urandom_range(0, 25)));
          end else if (pick < 9) begin
            text.push_back(8'($urandom_range(0, 255)));
          end else begin
            text.push_back(CH_PERCENT);
          end
        end
        foreach (text[i]) begin
          send_char(text[i], i == text.size() - 1);
        end
        sent += text.size();
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_mode <= MODE_ENCODE;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    in_last <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_encode_extremes();
    test_decode_escapes();
    test_decode_unreserved();
    test_normalise();
    test_escape_across_mode_change();
    test_backpressure();
    test_random_strings();

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/upc_pkg.sv
src/upc_core.sv
src/upc_out_buf.sv
src/uri_percent_codec.sv
test/uri_percent_codec_tb.sv
